FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers used by the RTL that checks itself.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, held off during reset.
`define SCA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m: check failed");

// Clocked assertion that is also checked during reset.
`define SCA_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("%m: check failed");

`endif

FILE: rtl/core/sca_pkg.sv
// ----------------------------------------------------------------------------
// sca_pkg
// Shared types and constants of the scaled currency ALU.
// ----------------------------------------------------------------------------
package sca_pkg;

  localparam int unsigned VAL_W = 64;
  localparam int unsigned SCL_W = 32;
  localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic [13:0] SCALE = 14'd10000;

  localparam logic [1:0] ORD_LT = 2'b11;
  localparam logic [1:0] ORD_EQ = 2'b00;
  localparam logic [1:0] ORD_GT = 2'b01;

  typedef enum logic [2:0] {
    FN_CMP = 3'd0,
    FN_ADD = 3'd1,
    FN_SUB = 3'd2,
    FN_NEG = 3'd3,
    FN_MUL = 3'd4,
    FN_DIV = 3'd5,
    FN_SET = 3'd6
  } func_t;

  // One item as it travels along the pipe.
  typedef struct packed {
    logic [2:0]       func;
    logic             av;
    logic [VAL_W-1:0] a;
    logic [VAL_W-1:0] res_value;
    logic             res_valid;
    logic [1:0]       order;
    logic [VAL_W-1:0] mul_lo;
    logic [VAL_W-1:0] mul_hi;
    logic             mul_neg;
    logic [VAL_W-1:0] dq;      // dividend shifting out, quotient shifting in
    logic [SCL_W:0]   rem;
    logic [SCL_W-1:0] dvs;
    logic             div_neg;
    logic             div_ok;
  } item_t;

endpackage

FILE: rtl/core/sca_prep.sv
// ----------------------------------------------------------------------------
// sca_prep
// Entry stage: simple operations, magnitudes and multiply partial products.
// ----------------------------------------------------------------------------
module sca_prep (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_vld,
  input  logic [2:0]          func,
  input  logic [63:0]         a,
  input  logic                av,
  input  logic [63:0]         b,
  input  logic                bv,
  input  logic [31:0]         s,
  input  logic [31:0]         fr,
  output logic                out_vld,
  output sca_pkg::item_t      out_item
);

  logic           vld_r;
  sca_pkg::item_t item_r;
  sca_pkg::item_t item_nxt;
  logic [63:0]    ua;
  logic [31:0]    uf;
  logic [31:0]    ufr;
  logic [63:0]    sum;
  logic [63:0]    diff;
  logic [45:0]    units;
  logic [63:0]    mag;

  always_comb begin
    ua   = a[63] ? (64'd0 - a) : a;
    uf   = s[31] ? (32'd0 - s) : s;
    ufr  = fr[31] ? (32'd0 - fr) : fr;
    sum  = a + b;
    diff = a - b;
    units = {14'd0, uf} * {32'd0, sca_pkg::SCALE};
    mag  = {18'd0, units} + {32'd0, ufr};

    item_nxt           = '0;
    item_nxt.func      = func;
    item_nxt.av        = av;
    item_nxt.a         = a;
    item_nxt.order     = sca_pkg::ORD_EQ;
    // 32 x 32 partial products, zero-extended to their full width
    item_nxt.mul_lo    = {32'd0, ua[31:0]} * {32'd0, uf};
    item_nxt.mul_hi    = {32'd0, ua[63:32]} * {32'd0, uf};
    item_nxt.mul_neg   = a[63] ^ s[31];
    item_nxt.dq        = ua;
    item_nxt.rem       = '0;
    item_nxt.dvs       = uf;
    item_nxt.div_neg   = a[63] ^ s[31];
    item_nxt.div_ok    = av && (s != 32'd0);

    case (func)
      sca_pkg::FN_CMP: begin
        if (av && bv) begin
          if ($signed(a) < $signed(b)) item_nxt.order = sca_pkg::ORD_LT;
          else if ($signed(a) > $signed(b)) item_nxt.order = sca_pkg::ORD_GT;
        end
      end
      sca_pkg::FN_ADD: begin
        if (av && bv && !((a[63] == b[63]) && (a[63] != sum[63]))) begin
          item_nxt.res_value = sum;
          item_nxt.res_valid = 1'b1;
        end
      end
      sca_pkg::FN_SUB: begin
        if (av && bv && !((a[63] != b[63]) && (a[63] != diff[63]))) begin
          item_nxt.res_value = diff;
          item_nxt.res_valid = 1'b1;
        end
      end
      sca_pkg::FN_NEG: begin
        if (!av) begin
          item_nxt.res_value = a;
        end else if (a != sca_pkg::VAL_MIN) begin
          item_nxt.res_value = 64'd0 - a;
          item_nxt.res_valid = 1'b1;
        end
      end
      sca_pkg::FN_SET: begin
        item_nxt.res_value = (s[31] | fr[31]) ? (64'd0 - mag) : mag;
        item_nxt.res_valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item_r <= item_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_item = item_r;

endmodule

FILE: rtl/core/sca_div_cell.sv
// ----------------------------------------------------------------------------
// sca_div_cell
// One cell of the divider row: STEPS restoring division steps, then a register.
// ----------------------------------------------------------------------------
module sca_div_cell #(
  parameter int unsigned STEPS = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           in_vld,
  input  sca_pkg::item_t in_item,
  output logic           out_vld,
  output sca_pkg::item_t out_item
);

  logic           vld_r;
  sca_pkg::item_t item_r;
  sca_pkg::item_t item_nxt;
  logic [32:0]    trial;

  always_comb begin
    item_nxt = in_item;
    trial    = '0;
    for (int i = 0; i < STEPS; i++) begin
      trial       = {item_nxt.rem[31:0], item_nxt.dq[63]};
      item_nxt.dq = {item_nxt.dq[62:0], 1'b0};
      if (trial >= {1'b0, item_nxt.dvs}) begin
        item_nxt.rem   = trial - {1'b0, item_nxt.dvs};
        item_nxt.dq[0] = 1'b1;
      end else begin
        item_nxt.rem   = trial;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item_r <= item_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_item = item_r;

endmodule

FILE: rtl/core/sca_post.sv
// ----------------------------------------------------------------------------
// sca_post
// Final stage: multiply range check, quotient sign, output register.
// ----------------------------------------------------------------------------
module sca_post (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           in_vld,
  input  sca_pkg::item_t in_item,
  output logic           out_vld,
  output logic [63:0]    value,
  output logic           valid,
  output logic [1:0]     order,
  output logic [2:0]     func
);

  logic        vld_r;
  logic [63:0] value_r, value_nxt;
  logic        valid_r, valid_nxt;
  logic [1:0]  order_r;
  logic [2:0]  func_r;
  logic [63:0] mid;
  logic [63:0] mag;
  logic [63:0] q;

  always_comb begin
    value_nxt = in_item.res_value;
    valid_nxt = in_item.res_valid;
    mid = in_item.mul_hi + {32'd0, in_item.mul_lo[63:32]};
    mag = {mid[31:0], in_item.mul_lo[31:0]};
    q   = in_item.dq;
    case (in_item.func)
      sca_pkg::FN_MUL: begin
        value_nxt = '0;
        valid_nxt = 1'b0;
        if (!in_item.av) begin
          value_nxt = in_item.a;
        end else if (mid[63:32] == 32'd0) begin
          if (in_item.mul_neg && (mag <= sca_pkg::VAL_MIN)) begin
            value_nxt = 64'd0 - mag;
            valid_nxt = 1'b1;
          end else if (!in_item.mul_neg && !mag[63]) begin
            value_nxt = mag;
            valid_nxt = 1'b1;
          end
        end
      end
      sca_pkg::FN_DIV: begin
        value_nxt = '0;
        valid_nxt = 1'b0;
        if (in_item.div_ok) begin
          if (in_item.div_neg) begin
            value_nxt = 64'd0 - q;
            valid_nxt = 1'b1;
          end else if (!q[63]) begin
            value_nxt = q;
            valid_nxt = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      value_r <= value_nxt;
      valid_r <= valid_nxt;
      order_r <= in_item.order;
      func_r  <= in_item.func;
    end
  end

  assign out_vld = vld_r;
  assign value   = value_r;
  assign valid   = valid_r;
  assign order   = order_r;
  assign func    = func_r;

endmodule

FILE: rtl/core/scaled_currency_alu.sv
// ----------------------------------------------------------------------------
// scaled_currency_alu
// Pipelined ALU for 64-bit signed currency values scaled by 10000.
// ----------------------------------------------------------------------------
// Use:
//   One item on the in_ channel carries an operation code and its operands;
//   each item gives exactly one result item on the out_ channel, in order.
//   Channels move an item when valid is high and stall is low.
// Pipeline: NUM_CELLS + 2 register stages (one entry stage, a row of divider
//   cells of four division steps each by default, one output register); an
//   accepted item passes them in that order before out_valid rises.
//   Every item, whatever its operation, travels the whole row so results
//   leave in order.
// Throughput: one item per cycle unless the pipe is stalled; the row of cells
//   takes a new item each unstalled cycle while older ones are being divided.
// Stall: when the receiver stalls with a result waiting, the whole pipe holds
//   and in_stall rises in the same cycle; nothing is lost or repeated.
// Reset: rst_n low for one clock empties every stage; no item is in flight.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scaled_currency_alu #(
  parameter int unsigned STEPS_PER_CELL = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_func,
  input  logic signed [63:0] in_lhs_value,
  input  logic               in_lhs_valid,
  input  logic signed [63:0] in_rhs_value,
  input  logic               in_rhs_valid,
  input  logic signed [31:0] in_scalar,
  input  logic signed [31:0] in_fraction,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] out_result_value,
  output logic               out_result_valid,
  output logic signed [1:0]  out_order
);

  // quotient bits are produced STEPS_PER_CELL per cell
  localparam int unsigned NUM_CELLS = sca_pkg::VAL_W / STEPS_PER_CELL;

  logic                 adv;
  logic [NUM_CELLS:0]   vld;
  sca_pkg::item_t       item [NUM_CELLS+1];
  logic [63:0]          res_value;
  logic [1:0]           res_order;
  logic [2:0]           res_func;

  // the pipe moves unless a finished result is held up by the receiver
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  sca_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (in_valid),
    .func     (in_func),
    .a        (in_lhs_value),
    .av       (in_lhs_valid),
    .b        (in_rhs_value),
    .bv       (in_rhs_valid),
    .s        (in_scalar),
    .fr       (in_fraction),
    .out_vld  (vld[0]),
    .out_item (item[0])
  );

  // the divider row: each cell resolves STEPS_PER_CELL quotient bits
  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    sca_div_cell #(
      .STEPS (STEPS_PER_CELL)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .in_vld   (vld[g]),
      .in_item  (item[g]),
      .out_vld  (vld[g+1]),
      .out_item (item[g+1])
    );
  end

  sca_post u_post (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (vld[NUM_CELLS]),
    .in_item (item[NUM_CELLS]),
    .out_vld (out_valid),
    .value   (res_value),
    .valid   (out_result_valid),
    .order   (res_order),
    .func    (res_func)
  );

  assign out_result_value = res_value;
  assign out_order        = res_order;

  // only a compare may report an order
  `SCA_ASSERT(a_order_cmp_only, clk, rst_n, (out_valid && (res_func != sca_pkg::FN_CMP)) |-> (res_order == sca_pkg::ORD_EQ))
  // a compare never yields a valid value
  `SCA_ASSERT(a_cmp_no_value, clk, rst_n, (out_valid && (res_func == sca_pkg::FN_CMP)) |-> (!out_result_valid && (res_value == 64'd0)))
  // a held pipe keeps every stage's occupancy
  `SCA_ASSERT(a_hold_row, clk, rst_n, !adv |=> $stable(vld))
  // order never carries the unused code
  `SCA_ASSERT(a_order_code, clk, rst_n, out_valid |-> (res_order != 2'b10))

endmodule
